// ===== hw/rtl/fptw_pkg.sv =====
`default_nettype none

package fptw_pkg;

  // Table geometry and field widths
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int FLAG_W            = 12;
  localparam int FRAME_W           = 40;
  localparam int ENTRY_W           = 64;

  // Operation codes
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_MAP    = 2'd1;
  localparam logic [1:0] KIND_UNMAP  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMAPPED  = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TABLE_BASE = 2'd0;
  localparam logic [1:0] CFG_POOL_START = 2'd1;
  localparam logic [1:0] CFG_POOL_END   = 2'd2;

  // Entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_USER    = 2;
  localparam int BIT_LARGE   = 7;

  // Walk level of the page table itself
  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VA_W-1:0]   virtual_address;
    logic [PA_W-1:0]   physical_address;
    logic [FLAG_W-1:0] leaf_flags_in;
    logic              executable;
  } fptw_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FLAG_W-1:0] leaf_flags;
    logic [PA_W-1:0]   old_frame_address;
    logic              release_frame;
  } fptw_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } fptw_state_t;

  // Table index taken from the virtual address at each walk level.
  function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/four_level_page_table_walker_top.sv =====
// Walk: a walk reads and then evaluates one entry per level on the single table memory
// port, then passes a result stage; walks that stop early are shorter, and an unknown
// kind goes straight to the result stage.
// One item at a time: a new item is taken only once the last result is in the output register.
// Reset: synchronous; afterwards a clearing pass writes zero to every word of the
// table memory, during which no item is taken. Configuration writes are taken at any time.
`default_nettype none

module four_level_page_table_walker_top
  import fptw_pkg::*;
#(
  parameter int TABLE_FRAMES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire fptw_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output fptw_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [PA_W-1:0] cfg_wdata
);

  localparam int FW        = $clog2(TABLE_FRAMES);
  localparam int AW        = FW + IDX_W;
  localparam int MEM_DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam logic [AW-1:0]      LAST_ADDR     = AW'(MEM_DEPTH - 1);
  localparam logic [FW:0]        FRAMES_LIMIT  = (FW + 1)'(TABLE_FRAMES);
  localparam logic [FRAME_W-1:0] PTR_LIMIT     = FRAME_W'(TABLE_FRAMES);

  // Configuration registers
  logic [PA_W-1:0] table_region_base;
  logic [PA_W-1:0] frame_pool_start;
  logic [PA_W-1:0] frame_pool_end;

  // Control state
  fptw_state_t     state, state_next;
  logic [1:0]      lvl, lvl_next;
  logic [FW-1:0]   cur, cur_next;
  logic [FW:0]     next_table_frame, next_table_frame_next;
  logic [AW-1:0]   clr_addr, clr_addr_next;

  // Operation being walked
  logic              load_op;
  logic [1:0]        op_kind;
  logic [VA_W-1:0]   op_va;
  logic [PA_W-1:0]   op_pa;
  logic [FLAG_W-1:0] op_flags;
  logic              op_exec;

  // Result being built
  logic [1:0]        res_status, res_status_next;
  logic [FLAG_W-1:0] res_flags, res_flags_next;
  logic [PA_W-1:0]   res_old, res_old_next;
  logic              res_release;
  logic              out_load;

  // Table memory: each word carries an entry and a mark that says the word was written
  // while its frame was allocated. Words written before their frame was allocated read
  // as zero once it is, which stands for zeroing the new table.
  logic [ENTRY_W:0]  table_mem [MEM_DEPTH];
  logic [ENTRY_W:0]  mem_rdata;
  logic [ENTRY_W:0]  mem_wdata;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic              mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= table_mem[mem_addr];
    end
  end

  // Entry decode and pointer arithmetic on the word just read
  logic [IDX_W-1:0]   idx;
  logic               cur_alloc;
  logic [ENTRY_W-1:0] entry;
  logic               user_bit;
  logic [FRAME_W-1:0] ptr_off;
  logic               ptr_ok;
  logic [FRAME_W-1:0] new_ptr;
  logic               pool_full;
  logic [ENTRY_W-1:0] leaf_word;
  logic [ENTRY_W-1:0] new_entry;
  logic [ENTRY_W-1:0] upd_entry;

  assign idx       = table_index(op_va, lvl);
  assign cur_alloc = ({1'b0, cur} < next_table_frame);
  assign entry     = (mem_rdata[ENTRY_W] || !cur_alloc) ? mem_rdata[ENTRY_W-1:0]
                                                        : '0;
  assign user_bit  = op_flags[BIT_USER];
  assign ptr_off   = entry[51:12] - table_region_base[51:12];
  assign ptr_ok    = (ptr_off < PTR_LIMIT);
  assign new_ptr   = table_region_base[51:12] + FRAME_W'(next_table_frame[FW-1:0]);
  assign pool_full = (next_table_frame == FRAMES_LIMIT);
  assign leaf_word = {~op_exec, 11'b0, op_pa[51:12], op_flags | 12'h001};
  assign new_entry = {12'b0, new_ptr, 9'b0, user_bit, 2'b11};
  assign upd_entry = entry | {61'b0, user_bit, 2'b00};

  // Release test on the frame an unmap has cleared
  assign res_release = (res_old != '0) && (res_old >= frame_pool_start) &&
                       (res_old < frame_pool_end);

  // State register and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      next_table_frame <= (FW + 1)'(1);
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      clr_addr         <= clr_addr_next;
      next_table_frame <= next_table_frame_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl        <= lvl_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_flags  <= res_flags_next;
    res_old    <= res_old_next;
    if (load_op) begin
      op_kind  <= in_data.kind;
      op_va    <= in_data.virtual_address;
      op_pa    <= in_data.physical_address;
      op_flags <= in_data.leaf_flags_in;
      op_exec  <= in_data.executable;
    end
    if (out_load) begin
      out_data.status            <= res_status;
      out_data.leaf_flags        <= res_flags;
      out_data.old_frame_address <= res_old;
      out_data.release_frame     <= res_release;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_region_base <= '0;
      frame_pool_start  <= '0;
      frame_pool_end    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_BASE: table_region_base <= cfg_wdata;
        CFG_POOL_START: frame_pool_start  <= cfg_wdata;
        CFG_POOL_END:   frame_pool_end    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state, memory control and walk decisions
  always_comb begin
    state_next            = state;
    lvl_next              = lvl;
    cur_next              = cur;
    next_table_frame_next = next_table_frame;
    clr_addr_next         = clr_addr;
    res_status_next       = res_status;
    res_flags_next        = res_flags;
    res_old_next          = res_old;
    mem_we                = 1'b0;
    mem_re                = 1'b0;
    mem_addr              = {cur, idx};
    mem_wdata             = {cur_alloc, upd_entry};
    in_ready              = 1'b0;
    load_op               = 1'b0;
    out_load              = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_addr      = clr_addr;
        mem_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load_op         = 1'b1;
          lvl_next        = 2'd0;
          cur_next        = '0;
          res_status_next = ST_UNMAPPED;
          res_flags_next  = '0;
          res_old_next    = '0;
          if (in_data.kind inside {KIND_LOOKUP, KIND_MAP, KIND_UNMAP}) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_READ: begin
        mem_re     = 1'b1;
        state_next = S_EVAL;
      end

      S_EVAL: begin
        state_next = S_DONE;
        if (lvl != LEVEL_LEAF) begin
          case (op_kind)
            KIND_MAP: begin
              if (!entry[BIT_PRESENT]) begin
                // Missing table: take a frame from the bump allocator. A parent word
                // that lies in the frame being taken is written after its zeroing.
                if (pool_full) begin
                  res_status_next = ST_POOL_FULL;
                end else begin
                  mem_we                = 1'b1;
                  mem_wdata             = {({1'b0, cur} <= next_table_frame), new_entry};
                  next_table_frame_next = next_table_frame + 1'b1;
                  cur_next              = next_table_frame[FW-1:0];
                  lvl_next              = lvl + 2'd1;
                  state_next            = S_READ;
                end
              end else if (!entry[BIT_LARGE]) begin
                // Existing table: add the user bit, then follow the pointer if it lies in the table region
                mem_we = 1'b1;
                if (ptr_ok) begin
                  cur_next   = ptr_off[FW-1:0];
                  lvl_next   = lvl + 2'd1;
                  state_next = S_READ;
                end
              end
            end
            default: begin
              if (entry[BIT_PRESENT] && !entry[BIT_LARGE] && ptr_ok) begin
                cur_next   = ptr_off[FW-1:0];
                lvl_next   = lvl + 2'd1;
                state_next = S_READ;
              end
            end
          endcase
        end else begin
          case (op_kind)
            KIND_LOOKUP: begin
              if (entry[BIT_PRESENT]) begin
                res_status_next = ST_OK;
                res_flags_next  = entry[FLAG_W-1:0];
              end
            end
            KIND_MAP: begin
              mem_we          = 1'b1;
              mem_wdata       = {cur_alloc, leaf_word};
              res_status_next = ST_OK;
            end
            default: begin
              // Unmap clears the leaf whether or not it was present
              mem_we          = 1'b1;
              mem_wdata       = '0;
              res_status_next = ST_OK;
              res_old_next    = {entry[51:12], 12'b0};
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The allocator stays between its reset value and the frame count.
  assert property (@(posedge clk) disable iff (rst)
    (next_table_frame != '0) && (next_table_frame <= FRAMES_LIMIT))
    else $error("table frame allocator out of range");

  // Only a map walk moves the allocator.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (next_table_frame != $past(next_table_frame))) |->
    ($past(state) == S_EVAL && $past(op_kind) == KIND_MAP))
    else $error("allocator moved outside a map walk");

  // A lookup never writes the table memory.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR && state != S_IDLE && op_kind == KIND_LOOKUP) |-> !mem_we)
    else $error("lookup wrote the table memory");

  // Memory reads and writes never share a cycle on the single port.
  assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (!mem_we && state == S_READ))
    else $error("table memory port conflict");

endmodule

`default_nettype wire
